@@ sv/mstk_pkg.sv @@
// ---------------------------------------------------------------------------
// mstk_pkg
// Shared sizes, codes and types for the Kruskal spanning tree block.
// ---------------------------------------------------------------------------
package mstk_pkg;

	localparam int MAX_V   = 64;
	localparam int VIDX_W  = $clog2(MAX_V);
	localparam int VCNT_W  = VIDX_W + 1;
	localparam int MAX_E   = 256;
	localparam int EIDX_W  = $clog2(MAX_E);
	localparam int ECNT_W  = EIDX_W + 1;
	localparam int W_BITS  = 16;

	localparam logic [VCNT_W-1:0] ROOT_MARK = '1;

	typedef enum logic [1:0] {
		ST_EDGE     = 2'd0,
		ST_NOT_CONN = 2'd1,
		ST_IN_ERR   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [W_BITS-1:0] w;
		logic [VIDX_W-1:0]        b;
		logic [VIDX_W-1:0]        a;
	} edge_t;

	// union-find request / response
	typedef struct packed {
		logic              clear;
		logic              go;
		logic [VIDX_W-1:0] a;
		logic [VIDX_W-1:0] b;
	} uf_req_t;

	typedef struct packed {
		logic done;
		logic joined;
	} uf_rsp_t;

endpackage

@@ sv/minimum_spanning_tree_kruskal.sv @@
// ---------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Loads weighted edges, then selects a minimum spanning tree by Kruskal's
// method and streams the tree edges out in ascending weight order, or one status result.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake            Contents
// s_axis    in   tvalid/tready        tdata: first, second vertex, weight; tlast: last edge
// m_axis    out  tvalid/tready        tdata: tree edge; tuser: status; tlast: last result
// cfg       in   cfg_valid/cfg_ready  cfg_data: vertex_count
//
// Edges load one per cycle. After the last edge, each selection is a full
// scan of the edge store followed by two root walks, one link read per
// step, and a hand-over; there is up to one selection per stored edge,
// ending early once vertex_count-1 edges are kept. Results are read from
// the kept-edge store one at a time. Input is held off for the whole run.
// Reset puts vertex_count at 64 and empties the edge store; no clearing pass.
// ---------------------------------------------------------------------------
module minimum_spanning_tree_kruskal (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // first_vertex[5:0], second_vertex[11:6], edge_weight[27:12]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // tree_first[5:0], tree_second[11:6], tree_weight[27:12]
	output logic [1:0]  m_axis_tuser,  // result_status[1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UNION, S_EMIT_RD, S_EMIT_LD, S_STAT} state_t;

	localparam int VI = mstk_pkg::VIDX_W;
	localparam int VC = mstk_pkg::VCNT_W;
	localparam int EC = mstk_pkg::ECNT_W;
	localparam int EI = mstk_pkg::EIDX_W;

	state_t                     state_q;
	logic [VC-1:0]              vcount_q;
	logic [VC-1:0]              nv;
	logic [EC-1:0]              etotal_q;
	logic                       err_q;
	logic [mstk_pkg::MAX_E-1:0] taken_q;
	logic [VI-1:0]              need_q;
	logic [VI-1:0]              cnt_q;
	logic [VI-1:0]              emit_k_q;
	logic [EC-1:0]              scan_idx_q;
	logic                       rd_vld_s1;
	logic [EI-1:0]              idx_s1;
	mstk_pkg::edge_t            edge_rd_s1;
	mstk_pkg::edge_t            best_q;
	logic [EI-1:0]              best_idx_q;
	logic                       found_q;
	mstk_pkg::edge_t            edge_mem [mstk_pkg::MAX_E];
	mstk_pkg::edge_t            tree_mem [mstk_pkg::MAX_V];
	mstk_pkg::edge_t            tree_rd_q;
	mstk_pkg::edge_t            in_edge;
	mstk_pkg::status_t          out_stat_q;
	mstk_pkg::status_t          stat_q;
	mstk_pkg::uf_req_t          uf_req;
	mstk_pkg::uf_rsp_t          uf_rsp;
	logic                       in_acc;
	logic                       in_bad;
	logic                       issue;
	logic                       better;
	logic                       out_free;
	logic [31:0]                out_data_q;
	logic                       out_last_q;
	logic                       out_vld_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_edge       = s_axis_tdata[27:0];

	always_comb begin
		if (vcount_q == '0) begin
			nv = VC'(1);
		end else if (vcount_q > VC'(mstk_pkg::MAX_V)) begin
			nv = VC'(mstk_pkg::MAX_V);
		end else begin
			nv = vcount_q;
		end
	end

	assign in_bad = ({1'b0, in_edge.a} >= nv) || ({1'b0, in_edge.b} >= nv)
		|| (etotal_q >= EC'(mstk_pkg::MAX_E));

	assign issue  = (state_q == S_SCAN) && (scan_idx_q < etotal_q);
	// strict compare keeps the earlier edge on a tie
	assign better = rd_vld_s1 && !taken_q[idx_s1]
		&& (!found_q || (edge_rd_s1.w < best_q.w));
	assign out_free = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

	// edge store and kept-edge store
	always_ff @(posedge clk) begin
		if (in_acc && !in_bad) begin
			edge_mem[etotal_q[EI-1:0]] <= in_edge;
		end
		edge_rd_s1 <= edge_mem[scan_idx_q[EI-1:0]];
		if ((state_q == S_UNION) && uf_rsp.done && uf_rsp.joined) begin
			tree_mem[cnt_q] <= best_q;
		end
		tree_rd_q <= tree_mem[emit_k_q];
	end

	mstk_uf u_uf (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (uf_req),
		.rsp    (uf_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vcount_q   <= VC'(mstk_pkg::MAX_V);
			etotal_q   <= '0;
			err_q      <= 1'b0;
			taken_q    <= '0;
			need_q     <= '0;
			cnt_q      <= '0;
			emit_k_q   <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			idx_s1     <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			uf_req     <= '0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_stat_q <= mstk_pkg::ST_EDGE;
			stat_q     <= mstk_pkg::ST_EDGE;
			out_last_q <= 1'b0;
		end else begin
			uf_req.go    <= 1'b0;
			uf_req.clear <= 1'b0;
			if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			rd_vld_s1 <= issue;
			idx_s1    <= scan_idx_q[EI-1:0];

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_bad) begin
							err_q <= 1'b1;
						end else begin
							etotal_q <= etotal_q + EC'(1);
						end
						if (s_axis_tlast) begin
							if (err_q || in_bad) begin
								stat_q  <= mstk_pkg::ST_IN_ERR;
								state_q <= S_STAT;
							end else if (nv == VC'(1)) begin
								etotal_q <= '0;
							end else begin
								need_q       <= VI'(nv - VC'(1));
								cnt_q        <= '0;
								uf_req.clear <= 1'b1;
								scan_idx_q   <= '0;
								found_q      <= 1'b0;
								state_q      <= S_SCAN;
							end
							err_q   <= 1'b0;
							taken_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + EC'(1);
					end
					if (better) begin
						best_q     <= edge_rd_s1;
						best_idx_q <= idx_s1;
						found_q    <= 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						if (!found_q) begin
							stat_q  <= mstk_pkg::ST_NOT_CONN;
							state_q <= S_STAT;
						end else begin
							taken_q[best_idx_q] <= 1'b1;
							uf_req.go <= 1'b1;
							uf_req.a  <= best_q.a;
							uf_req.b  <= best_q.b;
							state_q   <= S_UNION;
						end
					end
				end
				S_UNION: begin
					if (uf_rsp.done) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						if (uf_rsp.joined && (cnt_q + VI'(1) == need_q)) begin
							emit_k_q <= '0;
							state_q  <= S_EMIT_RD;
						end else begin
							state_q <= S_SCAN;
						end
						if (uf_rsp.joined) begin
							cnt_q <= cnt_q + VI'(1);
						end
					end
				end
				S_EMIT_RD: begin
					etotal_q <= '0;
					taken_q  <= '0;
					state_q  <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {4'b0, tree_rd_q};
						out_stat_q <= mstk_pkg::ST_EDGE;
						out_last_q <= (emit_k_q == need_q - VI'(1));
						if (emit_k_q == need_q - VI'(1)) begin
							state_q <= S_IDLE;
						end else begin
							emit_k_q <= emit_k_q + VI'(1);
							state_q  <= S_EMIT_RD;
						end
					end
				end
				S_STAT: begin
					etotal_q <= '0;
					taken_q  <= '0;
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= '0;
						out_stat_q <= stat_q;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/mstk_uf.sv @@
// ---------------------------------------------------------------------------
// mstk_uf
// Union-find: walks both endpoints to their roots, one link read per step,
// and links the first root to the second when they differ.
// ---------------------------------------------------------------------------
module mstk_uf (
	input  logic             clk,
	input  logic             arst_n,
	input  mstk_pkg::uf_req_t req,
	output mstk_pkg::uf_rsp_t rsp
);

	typedef enum logic [1:0] {U_IDLE, U_RD, U_CHK} ustate_t;

	ustate_t                           state_q;
	logic [mstk_pkg::VCNT_W-1:0]       link_mem [mstk_pkg::MAX_V];
	logic [mstk_pkg::VCNT_W-1:0]       link_rd_q;
	logic [mstk_pkg::MAX_V-1:0]        vld_q;
	logic [mstk_pkg::VIDX_W-1:0]       x_q;
	logic [mstk_pkg::VIDX_W-1:0]       b_q;
	logic [mstk_pkg::VIDX_W-1:0]       r1_q;
	logic                              second_q;
	logic                              wr_en;
	logic                              at_root;

	// an entry never written is still a root
	assign at_root = !vld_q[x_q] || (link_rd_q == mstk_pkg::ROOT_MARK)
		|| link_rd_q[mstk_pkg::VCNT_W-1];
	assign wr_en = (state_q == U_CHK) && at_root && second_q && (r1_q != x_q);

	always_ff @(posedge clk) begin
		link_rd_q <= link_mem[x_q];
		if (wr_en) begin
			link_mem[r1_q] <= {1'b0, x_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= U_IDLE;
			vld_q    <= '0;
			x_q      <= '0;
			b_q      <= '0;
			r1_q     <= '0;
			second_q <= 1'b0;
			rsp      <= '0;
		end else begin
			rsp <= '0;
			if (req.clear) begin
				vld_q <= '0;
			end
			unique case (state_q)
				U_IDLE: begin
					if (req.go) begin
						x_q      <= req.a;
						b_q      <= req.b;
						second_q <= 1'b0;
						state_q  <= U_RD;
					end
				end
				U_RD: begin
					state_q <= U_CHK;
				end
				U_CHK: begin
					if (!at_root) begin
						x_q     <= link_rd_q[mstk_pkg::VIDX_W-1:0];
						state_q <= U_RD;
					end else if (!second_q) begin
						r1_q     <= x_q;
						x_q      <= b_q;
						second_q <= 1'b1;
						state_q  <= U_RD;
					end else begin
						if (wr_en) begin
							vld_q[r1_q] <= 1'b1;
						end
						rsp.done   <= 1'b1;
						rsp.joined <= wr_en;
						state_q    <= U_IDLE;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

endmodule

@@ sv/mstk_checker.sv @@
// ---------------------------------------------------------------------------
// mstk_checker
// Port-level checks on the result stream of the spanning tree block.
// ---------------------------------------------------------------------------
module mstk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != mstk_pkg::ST_EDGE) |-> m_axis_tlast)
		else $error("status result not final");

	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != mstk_pkg::ST_EDGE) |-> (m_axis_tdata == 32'd0))
		else $error("status result carries edge data");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tuser == mstk_pkg::ST_EDGE)
			|| (m_axis_tuser == mstk_pkg::ST_NOT_CONN)
			|| (m_axis_tuser == mstk_pkg::ST_IN_ERR)))
		else $error("undefined status code");

endmodule

bind minimum_spanning_tree_kruskal mstk_checker u_mstk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/minimum_spanning_tree_kruskal_tb.sv @@
// ---------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_tb
// Streams edge lists into the spanning tree block and checks every tree
// edge and status result against a Kruskal predictor kept in the bench.
// A directed table covers the edge cases, then random graphs and a store overflow run follow.
// ---------------------------------------------------------------------------
module minimum_spanning_tree_kruskal_tb;

	localparam int RUN_ITEMS = 330;
	// random graphs stop here, leaving room for the store overflow run
	localparam int RAND_END  = RUN_ITEMS - mstk_pkg::MAX_E - 1;
	localparam int IDLE_WAIT = 64;
	localparam int HOLD_LEN  = 3000;

	typedef struct {
		logic [5:0]         first;
		logic [5:0]         second;
		logic signed [15:0] weight;
		mstk_pkg::status_t  status;
		logic               last;
	} tree_res_t;

	typedef struct {
		int                 cfg;      // -1: leave vertex_count alone
		logic [5:0]         a;
		logic [5:0]         b;
		logic signed [15:0] w;
		logic               last;
		bit                 typed;    // expected status given in the row
		mstk_pkg::status_t  st;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	minimum_spanning_tree_kruskal dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// bench copy of the block state
	logic [5:0]         edge_a [mstk_pkg::MAX_E];
	logic [5:0]         edge_b [mstk_pkg::MAX_E];
	logic signed [15:0] edge_w [mstk_pkg::MAX_E];
	int                 edge_cnt = 0;
	bit                 bad_input = 0;
	logic [6:0]         vcount = 7'd64;

	tree_res_t tree_q[$];
	int        mismatches = 0;
	int        snd_idle = 0, rcv_idle = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_cycles = 0;
	int        items = 0;

	function automatic int live_vertices();
		if (vcount == 0) return 1;
		if (vcount > mstk_pkg::MAX_V) return mstk_pkg::MAX_V;
		return vcount;
	endfunction

	// One edge into the predictor; on the last edge runs selection and
	// appends the results to the tree queue if keep is set.
	function automatic void kruskal_predict(logic [5:0] a, logic [5:0] b,
			logic signed [15:0] w, logic last, bit keep);
		int        nv, need, kept, best, ra, rb;
		int        parent [mstk_pkg::MAX_V];
		bit        taken [mstk_pkg::MAX_E];
		tree_res_t r;
		tree_res_t run_out[$];
		nv = live_vertices();
		if (a >= nv || b >= nv || edge_cnt >= mstk_pkg::MAX_E) bad_input = 1;
		else begin
			edge_a[edge_cnt] = a;
			edge_b[edge_cnt] = b;
			edge_w[edge_cnt] = w;
			edge_cnt++;
		end
		if (!last) return;
		if (bad_input) begin
			r = '{6'd0, 6'd0, 16'sd0, mstk_pkg::ST_IN_ERR, 1'b1};
			run_out.push_back(r);
		end else begin
			foreach (parent[i]) parent[i] = -1;
			foreach (taken[i]) taken[i] = 0;
			need = nv - 1;
			kept = 0;
			while (kept < need) begin
				best = -1;
				for (int i = 0; i < edge_cnt; i++)
					if (!taken[i] && (best < 0 || edge_w[i] < edge_w[best])) best = i;
				if (best < 0) break;
				taken[best] = 1;
				ra = edge_a[best];
				while (parent[ra] >= 0) ra = parent[ra];
				rb = edge_b[best];
				while (parent[rb] >= 0) rb = parent[rb];
				if (ra != rb) begin
					parent[ra] = rb;
					r = '{edge_a[best], edge_b[best], edge_w[best], mstk_pkg::ST_EDGE, 1'b0};
					run_out.push_back(r);
					kept++;
				end
			end
			if (kept < need) begin
				run_out.delete();
				r = '{6'd0, 6'd0, 16'sd0, mstk_pkg::ST_NOT_CONN, 1'b1};
				run_out.push_back(r);
			end else if (run_out.size() > 0) begin
				run_out[run_out.size()-1].last = 1'b1;
			end
		end
		edge_cnt = 0;
		bad_input = 0;
		if (keep) foreach (run_out[i]) tree_q.push_back(run_out[i]);
	endfunction

	task automatic send_edge(logic [5:0] a, logic [5:0] b, logic signed [15:0] w,
			logic last, bit keep = 1);
		while ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata  = {4'd0, w, b, a};
		s_axis_tlast  = last;
		do @(posedge clk); while (!s_axis_tready);
		kruskal_predict(a, b, w, last, keep);
		items++;
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic write_vcount(logic [6:0] v);
		wait (tree_q.size() == 0);
		repeat (IDLE_WAIT) @(negedge clk);
		cfg_valid = 1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		vcount = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// receiver side, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cycles = HOLD_LEN;
		end
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		tree_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tree_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result tdata=%h tuser=%0d tlast=%b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				e = tree_q.pop_front();
				if (m_axis_tdata != {4'd0, e.weight, e.second, e.first} ||
						m_axis_tuser != e.status || m_axis_tlast != e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d-%0d w=%0d st=%0d last=%b, got tdata=%h st=%0d last=%b",
							e.first, e.second, e.weight, e.status, e.last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("minimum_spanning_tree_kruskal_tb NOT OK");
		$finish;
	end

	row_t rows[$] = '{
		'{-1,  0, 63, -16'sd32768, 1, 1, mstk_pkg::ST_NOT_CONN},
		'{ 4,  0,  1,  16'sd32767, 0, 0, mstk_pkg::ST_EDGE},
		'{-1,  1,  2, -16'sd32768, 0, 0, mstk_pkg::ST_EDGE},
		'{-1,  2,  3,  16'sd0,     0, 0, mstk_pkg::ST_EDGE},
		'{-1,  3,  3, -16'sd5,     0, 0, mstk_pkg::ST_EDGE},   // self loop
		'{-1,  0,  2, -16'sd1,     0, 0, mstk_pkg::ST_EDGE},
		'{-1,  1,  3,  16'sd5,     1, 0, mstk_pkg::ST_EDGE},
		'{-1,  0,  4,  16'sd1,     0, 0, mstk_pkg::ST_EDGE},   // vertex out of range
		'{-1,  0,  1,  16'sd1,     1, 1, mstk_pkg::ST_IN_ERR},
		'{-1,  0,  1,  16'sd7,     0, 0, mstk_pkg::ST_EDGE},   // equal weights
		'{-1,  1,  2,  16'sd7,     0, 0, mstk_pkg::ST_EDGE},
		'{-1,  2,  3,  16'sd7,     0, 0, mstk_pkg::ST_EDGE},
		'{-1,  0,  3,  16'sd7,     1, 0, mstk_pkg::ST_EDGE},
		'{ 1,  0,  0,  16'sd3,     1, 0, mstk_pkg::ST_EDGE},   // single vertex: silent
		'{-1,  1,  0,  16'sd0,     1, 1, mstk_pkg::ST_IN_ERR},
		'{ 0,  0,  0,  16'sd0,     1, 0, mstk_pkg::ST_EDGE},   // zero acts as one
		'{ 2, 42, 21, -16'sd21846, 1, 1, mstk_pkg::ST_IN_ERR},
		'{127, 63, 62, 16'sd100,   0, 0, mstk_pkg::ST_EDGE},   // above range acts as 64
		'{-1, 62, 63, -16'sd100,   1, 1, mstk_pkg::ST_NOT_CONN}
	};

	initial begin
		int nv, ne, graphs;
		logic [5:0] a, b;
		logic signed [15:0] w;
		tree_res_t r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		snd_idle = 29; rcv_idle = 58;
		foreach (rows[i]) begin
			if (rows[i].cfg >= 0) write_vcount(7'(rows[i].cfg));
			send_edge(rows[i].a, rows[i].b, rows[i].w, rows[i].last, !rows[i].typed);
			if (rows[i].typed) begin
				r = '{6'd0, 6'd0, 16'sd0, rows[i].st, 1'b1};
				tree_q.push_back(r);
			end
		end

		graphs = 0;
		while (items < RAND_END) begin
			if (items < 2 * RAND_END / 3) begin
				snd_idle = 29; rcv_idle = 58;
			end else begin
				snd_idle = 58; rcv_idle = 29;
			end
			case (graphs % 9)
				0:       write_vcount(7'd64);
				4:       write_vcount($urandom_range(1) ? 7'd0 : 7'd127);
				7:       write_vcount(7'd1);
				default: write_vcount(7'($urandom_range(2, 8)));
			endcase
			nv = live_vertices();
			ne = $urandom_range(1, (nv > 12) ? 12 : 2 * nv);
			if (graphs == 2) begin
				wait (tree_q.size() == 0);
				hold_req++;
			end
			for (int k = 0; k < ne; k++) begin
				if (nv < mstk_pkg::MAX_V && $urandom_range(99) < 4)
					a = 6'($urandom_range(nv, 63));
				else a = 6'($urandom_range(nv - 1));
				b = 6'($urandom_range(nv - 1));
				w = $urandom_range(2) ? 16'($urandom) : 16'($signed($urandom_range(6)) - 3);
				send_edge(a, b, w, k == ne - 1);
			end
			// with the receiver held, offer the next graph so the input stalls
			if (graphs == 2) begin
				for (int k = 0; k < 4; k++)
					send_edge(6'($urandom_range(nv - 1)), 6'($urandom_range(nv - 1)),
						16'($urandom), k == 3);
			end
			graphs++;
		end

		// more edges than the store holds
		snd_idle = 0; rcv_idle = 0;
		write_vcount(7'd64);
		for (int k = 0; k <= mstk_pkg::MAX_E; k++)
			send_edge(6'($urandom), 6'($urandom), 16'($urandom), k == mstk_pkg::MAX_E);

		wait (tree_q.size() == 0);
		repeat (200) @(negedge clk);
		if (mismatches == 0 && tree_q.size() == 0) begin
			$display("minimum_spanning_tree_kruskal_tb OK");
		end else begin
			$display("minimum_spanning_tree_kruskal_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ minimum_spanning_tree_kruskal.f @@
sv/mstk_pkg.sv
sv/mstk_uf.sv
sv/minimum_spanning_tree_kruskal.sv
sv/mstk_checker.sv
tb/sv/minimum_spanning_tree_kruskal_tb.sv
